// ===== rtl/bdot_pkg.sv =====
// Shared types and constants for the B-dot detumbling torque block.
package bdot_pkg;

  // Default field width of one magnetometer axis
  localparam int unsigned FIELD_BITS_DEF = 24;

  localparam int unsigned AXES       = 3;
  localparam int unsigned AX_W       = 2;
  localparam int unsigned GAIN_W     = 32;
  localparam int unsigned RATE_W     = 16;
  localparam int unsigned LIM_W      = 23;
  localparam int unsigned LIMSQ_W    = 2 * LIM_W;
  localparam int unsigned FRAC_W     = 16;   // gain is Q16.16
  localparam int unsigned TORQUE_W   = 24;
  localparam int unsigned OUT_DATA_W = ((AXES * TORQUE_W + 7) / 8) * 8;
  localparam int unsigned MUL_W      = 32;
  localparam int unsigned PROD_W     = 2 * MUL_W;
  localparam int unsigned N_W        = 31;   // normalized magnitude
  localparam int unsigned SUM_W      = 64;   // sum of squares, root scratch
  localparam int unsigned DVD_W      = N_W + LIM_W;
  localparam int unsigned CNT_W      = 5;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_RST  = 32'd65536000;
  localparam logic [RATE_W-1:0] RATE_RST  = 16'd100;
  localparam logic [LIM_W-1:0]  LIMIT_RST = 23'd200000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_R,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ACC,
    ST_NORM,
    ST_SQ,
    ST_SQ_ACC,
    ST_LIMSQ,
    ST_CHECK,
    ST_SQRT,
    ST_DIV_MUL,
    ST_DIV_INIT,
    ST_DIV_STEP,
    ST_DONE
  } state_e;

endpackage

// ===== rtl/bdot_detumble_torque.sv =====
// B-dot detumbling controller: magnetometer samples in, limited torque commands out.
//
// Each input word carries one body-frame magnetometer sample (x, y, z in nT). The block
// differences it against the previous sample (zero after reset, so the first command
// usually comes out limited), scales by sample_rate_hz and gain (Q16.16) to form
// -gain * dB/dt, and if the vector magnitude exceeds torque_limit scales all three axes
// by limit / magnitude (truncating toward zero) and sets the limited flag in tuser.
// One result word per sample. Everything runs through a single 32x32 multiplier, a
// bit-serial square root (32 steps) and a restoring divider (23 steps per axis) under
// one sequencer; s_axis_tready is high only while the sequencer is idle.
// The square root and divider run only when limiting is needed. Before squaring, all
// axes are shifted right one bit at a time (0 to FIELD_BITS+1 shifts) until the largest
// axis is below 2^31. The result sits in an output register, so a new sample is taken
// while the previous result waits; the sequencer only holds in its last step if that
// register is still occupied.
// Config writes (cfg_index_i: 0 gain, 1 sample_rate_hz, 2 torque_limit, 3 ignored) are
// always accepted and must only be issued while the block is idle.
module bdot_detumble_torque #(
  parameter int unsigned FieldBits = bdot_pkg::FIELD_BITS_DEF,
  localparam int unsigned InDataW = ((3 * FieldBits + 7) / 8) * 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // sample stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [InDataW-1:0]                   s_axis_tdata,   // field_x, field_y, field_z
  // torque stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [bdot_pkg::OUT_DATA_W-1:0]      m_axis_tdata,   // torque_x, torque_y, torque_z
  output logic                                 m_axis_tuser,   // limited
  // register writes
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [bdot_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [bdot_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned RW    = FieldBits + bdot_pkg::RATE_W;        // |d| * rate
  localparam int unsigned RPadW = (RW > 32) ? RW : 33;
  localparam int unsigned MW    = RW + bdot_pkg::GAIN_W - bdot_pkg::FRAC_W;
  localparam int unsigned AXES  = bdot_pkg::AXES;
  localparam int unsigned AX_W  = bdot_pkg::AX_W;
  localparam int unsigned LIM_W = bdot_pkg::LIM_W;
  localparam int unsigned SUM_W = bdot_pkg::SUM_W;
  localparam int unsigned TQ_W  = bdot_pkg::TORQUE_W;
  localparam int unsigned N_W_LOCAL = bdot_pkg::N_W;
  localparam logic [AX_W-1:0] AxLast = AX_W'(AXES - 1);
  localparam logic [bdot_pkg::CNT_W-1:0] CntLast = bdot_pkg::CNT_W'(LIM_W - 1);

  // ---------------------------------------------------------------- registers
  bdot_pkg::state_e state_q, state_d;
  logic [AX_W-1:0]              ax_q, ax_d;
  logic [bdot_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic                         out_valid_q, out_valid_d;

  logic [bdot_pkg::GAIN_W-1:0]  gain_q, gain_d;
  logic [bdot_pkg::RATE_W-1:0]  rate_q, rate_d;
  logic [LIM_W-1:0]             lim_q, lim_d;

  logic signed [FieldBits-1:0]  prev_q [AXES];
  logic signed [FieldBits-1:0]  prev_d [AXES];

  logic [FieldBits-1:0]         ad_q [AXES];
  logic [FieldBits-1:0]         ad_d [AXES];
  logic [AXES-1:0]              neg_q, neg_d;
  logic [RW-1:0]                r_q, r_d;
  logic [MW-1:0]                m_q [AXES];
  logic [MW-1:0]                m_d [AXES];
  logic [bdot_pkg::PROD_W-1:0]  prod_q, prod_d;
  logic [SUM_W-1:0]             sum_q, sum_d;     // sum of squares, then root remainder
  logic [SUM_W-1:0]             root_q, root_d;
  logic [SUM_W-1:0]             bit_q, bit_d;
  logic [31:0]                  rem_q, rem_d;
  logic [LIM_W-1:0]             dvd_q, dvd_d;     // dividend low bits, then quotient
  logic [LIM_W-1:0]             mag_q [AXES];
  logic [LIM_W-1:0]             mag_d [AXES];
  logic                         shifted_q, shifted_d;
  logic                         limited_q, limited_d;
  logic [bdot_pkg::OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic                         out_lim_q, out_lim_d;

  // ---------------------------------------------------------------- shared signals
  logic                         in_fire;
  logic                         out_free;
  logic                         ax_last;
  logic                         any_big;
  logic                         lim_over;
  logic [N_W_LOCAL-1:0]         n_sel;

  logic [bdot_pkg::MUL_W-1:0]   mul_a, mul_b;
  logic [bdot_pkg::PROD_W-1:0]  mul_p;

  logic [RPadW-1:0]             r_pad;
  logic signed [FieldBits-1:0]  cur_w  [AXES];
  logic signed [FieldBits:0]    diff_w [AXES];

  logic [SUM_W:0]               sq_trial;
  logic                         sq_ge;
  logic [32:0]                  dv_trial;
  logic                         dv_ge;
  logic [TQ_W-1:0]              tq_w [AXES];

  assign s_axis_tready = (state_q == bdot_pkg::ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign ax_last       = (ax_q == AxLast);
  assign cfg_ready_o   = 1'b1;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_lim_q;

  assign r_pad = RPadW'(r_q);
  assign n_sel = m_q[ax_q][N_W_LOCAL-1:0];

  // any axis still at or above 2^31 needs another shift
  always_comb begin
    any_big = 1'b0;
    for (int i = 0; i < AXES; i++) begin
      any_big = any_big | (|m_q[i][MW-1:N_W_LOCAL]);
    end
  end

  // prod_q holds limit^2 in the check step
  assign lim_over = sum_q > SUM_W'(prod_q[bdot_pkg::LIMSQ_W-1:0]);

  // sample difference, per axis
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      cur_w[i]  = s_axis_tdata[i*FieldBits +: FieldBits];
      diff_w[i] = (FieldBits+1)'(cur_w[i]) - (FieldBits+1)'(prev_q[i]);
    end
  end

  // the one multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      bdot_pkg::ST_MUL_R: begin
        mul_a = bdot_pkg::MUL_W'(ad_q[ax_q]);
        mul_b = bdot_pkg::MUL_W'(rate_q);
      end
      bdot_pkg::ST_MUL_LO: begin
        mul_a = r_pad[31:0];
        mul_b = gain_q;
      end
      bdot_pkg::ST_MUL_HI: begin
        mul_a = bdot_pkg::MUL_W'(r_pad[RPadW-1:32]);
        mul_b = gain_q;
      end
      bdot_pkg::ST_SQ: begin
        mul_a = bdot_pkg::MUL_W'(n_sel);
        mul_b = bdot_pkg::MUL_W'(n_sel);
      end
      bdot_pkg::ST_LIMSQ: begin
        mul_a = bdot_pkg::MUL_W'(lim_q);
        mul_b = bdot_pkg::MUL_W'(lim_q);
      end
      bdot_pkg::ST_DIV_MUL: begin
        mul_a = bdot_pkg::MUL_W'(n_sel);
        mul_b = bdot_pkg::MUL_W'(lim_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = bdot_pkg::PROD_W'(mul_a) * bdot_pkg::PROD_W'(mul_b);

  // square root and divider steps
  assign sq_trial = {1'b0, root_q} + {1'b0, bit_q};
  assign sq_ge    = {1'b0, sum_q} >= sq_trial;
  assign dv_trial = {rem_q, dvd_q[LIM_W-1]};
  assign dv_ge    = dv_trial >= {1'b0, root_q[31:0]};

  // output torque words: sign opposite to the field change
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      tq_w[i] = neg_q[i] ? (TQ_W'(0) - TQ_W'(mag_q[i])) : TQ_W'(mag_q[i]);
    end
  end

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bdot_pkg::ST_IDLE:     if (in_fire) state_d = bdot_pkg::ST_MUL_R;
      bdot_pkg::ST_MUL_R:    state_d = bdot_pkg::ST_MUL_LO;
      bdot_pkg::ST_MUL_LO:   state_d = bdot_pkg::ST_MUL_HI;
      bdot_pkg::ST_MUL_HI:   state_d = bdot_pkg::ST_ACC;
      bdot_pkg::ST_ACC:      state_d = ax_last ? bdot_pkg::ST_NORM : bdot_pkg::ST_MUL_R;
      bdot_pkg::ST_NORM:     state_d = any_big ? bdot_pkg::ST_NORM : bdot_pkg::ST_SQ;
      bdot_pkg::ST_SQ:       state_d = bdot_pkg::ST_SQ_ACC;
      bdot_pkg::ST_SQ_ACC:   state_d = ax_last ? bdot_pkg::ST_LIMSQ : bdot_pkg::ST_SQ;
      bdot_pkg::ST_LIMSQ:    state_d = bdot_pkg::ST_CHECK;
      bdot_pkg::ST_CHECK: begin
        state_d = (shifted_q || lim_over) ? bdot_pkg::ST_SQRT : bdot_pkg::ST_DONE;
      end
      bdot_pkg::ST_SQRT:     if (bit_q[0]) state_d = bdot_pkg::ST_DIV_MUL;
      bdot_pkg::ST_DIV_MUL:  state_d = bdot_pkg::ST_DIV_INIT;
      bdot_pkg::ST_DIV_INIT: state_d = bdot_pkg::ST_DIV_STEP;
      bdot_pkg::ST_DIV_STEP: begin
        if (cnt_q == CntLast) begin
          state_d = ax_last ? bdot_pkg::ST_DONE : bdot_pkg::ST_DIV_MUL;
        end
      end
      bdot_pkg::ST_DONE:     if (out_free) state_d = bdot_pkg::ST_IDLE;
      default:               state_d = bdot_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- datapath
  always_comb begin
    ax_d        = ax_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    gain_d      = gain_q;
    rate_d      = rate_q;
    lim_d       = lim_q;
    prev_d      = prev_q;
    ad_d        = ad_q;
    neg_d       = neg_q;
    r_d         = r_q;
    m_d         = m_q;
    prod_d      = prod_q;
    sum_d       = sum_q;
    root_d      = root_q;
    bit_d       = bit_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    mag_d       = mag_q;
    shifted_d   = shifted_q;
    limited_d   = limited_q;
    out_data_d  = out_data_q;
    out_lim_d   = out_lim_q;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        bdot_pkg::REG_GAIN:  gain_d = cfg_data_i;
        bdot_pkg::REG_RATE:  rate_d = cfg_data_i[bdot_pkg::RATE_W-1:0];
        bdot_pkg::REG_LIMIT: lim_d  = cfg_data_i[LIM_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_q && m_axis_tready) out_valid_d = 1'b0;

    case (state_q)
      bdot_pkg::ST_IDLE: begin
        if (in_fire) begin
          for (int i = 0; i < AXES; i++) begin
            ad_d[i]   = diff_w[i][FieldBits] ? FieldBits'(-diff_w[i])
                                             : FieldBits'(diff_w[i]);
            neg_d[i]  = !diff_w[i][FieldBits] && (diff_w[i] != '0);
            prev_d[i] = cur_w[i];
          end
          ax_d      = '0;
          sum_d     = '0;
          shifted_d = 1'b0;
        end
      end
      bdot_pkg::ST_MUL_R:  r_d = RW'(mul_p);
      bdot_pkg::ST_MUL_LO: m_d[ax_q] = MW'(mul_p[bdot_pkg::PROD_W-1:bdot_pkg::FRAC_W]);
      bdot_pkg::ST_MUL_HI: prod_d = mul_p;
      bdot_pkg::ST_ACC: begin
        // high partial product lands 32 bits up, less the Q16 fraction
        m_d[ax_q] = m_q[ax_q] + (MW'(prod_q) << bdot_pkg::FRAC_W);
        ax_d      = ax_last ? '0 : ax_q + 1'b1;
      end
      bdot_pkg::ST_NORM: begin
        if (any_big) begin
          for (int i = 0; i < AXES; i++) begin
            m_d[i] = m_q[i] >> 1;
          end
          shifted_d = 1'b1;
        end
      end
      bdot_pkg::ST_SQ: prod_d = mul_p;
      bdot_pkg::ST_SQ_ACC: begin
        sum_d = sum_q + SUM_W'(prod_q);
        ax_d  = ax_last ? '0 : ax_q + 1'b1;
      end
      bdot_pkg::ST_LIMSQ: prod_d = mul_p;
      bdot_pkg::ST_CHECK: begin
        limited_d = shifted_q || lim_over;
        root_d    = '0;
        bit_d     = {2'b01, {(SUM_W-2){1'b0}}};
        ax_d      = '0;
        // unscaled magnitudes are already within the limit
        for (int i = 0; i < AXES; i++) begin
          mag_d[i] = m_q[i][LIM_W-1:0];
        end
      end
      bdot_pkg::ST_SQRT: begin
        if (sq_ge) begin
          sum_d  = sum_q - sq_trial[SUM_W-1:0];
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
      end
      bdot_pkg::ST_DIV_MUL: prod_d = mul_p;
      bdot_pkg::ST_DIV_INIT: begin
        // quotient is at most the limit, so the top bits start below the root
        rem_d = 32'(prod_q[bdot_pkg::DVD_W-1:LIM_W]);
        dvd_d = prod_q[LIM_W-1:0];
        cnt_d = '0;
      end
      bdot_pkg::ST_DIV_STEP: begin
        rem_d = dv_ge ? 32'(dv_trial - {1'b0, root_q[31:0]}) : dv_trial[31:0];
        dvd_d = {dvd_q[LIM_W-2:0], dv_ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          mag_d[ax_q] = {dvd_q[LIM_W-2:0], dv_ge};
          ax_d        = ax_last ? '0 : ax_q + 1'b1;
        end
      end
      bdot_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = bdot_pkg::OUT_DATA_W'({tq_w[2], tq_w[1], tq_w[0]});
          out_lim_d   = limited_q;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- flops
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bdot_pkg::ST_IDLE;
      ax_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      gain_q      <= bdot_pkg::GAIN_RST;
      rate_q      <= bdot_pkg::RATE_RST;
      lim_q       <= bdot_pkg::LIMIT_RST;
      for (int i = 0; i < AXES; i++) begin
        prev_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      ax_q        <= ax_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      gain_q      <= gain_d;
      rate_q      <= rate_d;
      lim_q       <= lim_d;
      prev_q      <= prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ad_q       <= ad_d;
    neg_q      <= neg_d;
    r_q        <= r_d;
    m_q        <= m_d;
    prod_q     <= prod_d;
    sum_q      <= sum_d;
    root_q     <= root_d;
    bit_q      <= bit_d;
    rem_q      <= rem_d;
    dvd_q      <= dvd_d;
    mag_q      <= mag_d;
    shifted_q  <= shifted_d;
    limited_q  <= limited_d;
    out_data_q <= out_data_d;
    out_lim_q  <= out_lim_d;
  end

  // ---------------------------------------------------------------- checks
`ifndef SYNTHESIS
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bdot_pkg::ST_DIV_STEP |-> root_q[31:0] != '0 && root_q[SUM_W-1:32] == '0)
    else $error("divider started with zero or oversized root");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bdot_pkg::ST_DIV_STEP |-> rem_q < root_q[31:0])
    else $error("partial remainder not below divisor");

  a_sqrt_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bdot_pkg::ST_SQRT |-> $onehot(bit_q))
    else $error("square root step bit lost");
`endif

endmodule

// ===== tb/sv/tb_bdot_detumble_torque.sv =====
// Self-checking testbench for the B-dot detumbling torque block.
module tb_bdot_detumble_torque;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FIELD_W    = bdot_pkg::FIELD_BITS_DEF;
  localparam int unsigned IN_W       = ((3 * FIELD_W + 7) / 8) * 8;
  localparam int unsigned TORQUE_W   = bdot_pkg::TORQUE_W;
  localparam int unsigned OUT_DATA_W = bdot_pkg::OUT_DATA_W;
  localparam int unsigned CFG_IDX_W  = bdot_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W = bdot_pkg::CFG_DATA_W;
  localparam int unsigned GAIN_W     = bdot_pkg::GAIN_W;
  localparam int unsigned RATE_W     = bdot_pkg::RATE_W;
  localparam int unsigned LIM_W      = bdot_pkg::LIM_W;
  localparam int unsigned FRAC_W     = bdot_pkg::FRAC_W;
  localparam int          CYCLE_LIMIT   = 1_200_000;
  localparam int          HOLD_CYCLES   = 600;   // long output stall
  localparam int          SETTLE_CYCLES = 200;   // > worst time from accept to result
  localparam int          PHASES        = 8;
  localparam int          PHASE_WORDS   = 165;

  // index 3 is not decoded by the block
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef logic signed [FIELD_W-1:0]       field_t;
  typedef logic [2:0][FIELD_W-1:0]         sample_t;   // [0] = x in the low bits
  typedef logic [2:0][TORQUE_W-1:0]        axes_t;
  typedef struct packed {
    axes_t torque;
    logic  limited;
  } torque_t;

  localparam field_t FIELD_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
  localparam field_t FIELD_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // Shadow copy of the block's registers and of the last accepted sample
  logic [GAIN_W-1:0] gain_sh;
  logic [RATE_W-1:0] rate_sh;
  logic [LIM_W-1:0]  limit_sh;
  field_t            prev_field [3];

  torque_t torque_q [$];   // commands still owed by the block, oldest first
  int      errors = 0;
  int      cycle_cnt;
  logic    no_idle;        // both sides run flat out while set
  logic    hold_req;       // asks the torque sink for one long stall

  bdot_detumble_torque i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs or loses a word.
  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("%t timeout after %0d cycles, %0d commands outstanding",
             $time, cycle_cnt, torque_q.size());
    $display("[bdot_detumble_torque] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Torque predictor
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    lo = 64'd0;
    hi = 64'hFFFF_FFFF;
    while (lo < hi) begin
      mid = lo + (hi - lo + 64'd1) / 64'd2;
      if (mid * mid <= v) lo = mid;
      else hi = mid - 64'd1;
    end
    return lo;
  endfunction

  // Runs one accepted sample through the control law and queues the command.
  task automatic accept_sample(input sample_t smp);
    longint      diff;
    logic [127:0] wide;
    logic [63:0] mag [3];
    logic        neg [3];
    logic [63:0] peak;
    logic [63:0] sumsq;
    logic [63:0] root;
    logic [63:0] signed_mag;
    int          sh;
    int          a;
    torque_t     cmd;
    for (a = 0; a < 3; a++) begin
      diff   = longint'($signed(smp[a])) - longint'(prev_field[a]);
      neg[a] = diff > 0;   // torque opposes the field rate
      wide   = 128'(diff < 0 ? -diff : diff) * 128'(rate_sh) * 128'(gain_sh);
      mag[a] = 64'(wide >> FRAC_W);
      prev_field[a] = $signed(smp[a]);
    end
    peak = mag[0];
    if (mag[1] > peak) peak = mag[1];
    if (mag[2] > peak) peak = mag[2];
    // normalize so each axis fits 31 bits before squaring
    sh = 0;
    while ((peak >> sh) >= 64'h8000_0000) sh++;
    sumsq = 64'd0;
    for (a = 0; a < 3; a++) begin
      mag[a] = mag[a] >> sh;
      sumsq  = sumsq + mag[a] * mag[a];
    end
    cmd.limited = (sh > 0) || (sumsq > 64'(limit_sh) * 64'(limit_sh));
    if (cmd.limited) begin
      root = floor_sqrt(sumsq);
      if (root == 64'd0) root = 64'd1;
      for (a = 0; a < 3; a++) mag[a] = (mag[a] * 64'(limit_sh)) / root;
    end else begin
      // undo the shift: sh is zero here anyway
      for (a = 0; a < 3; a++) mag[a] = mag[a] << sh;
    end
    for (a = 0; a < 3; a++) begin
      signed_mag     = neg[a] ? (64'd0 - mag[a]) : mag[a];
      cmd.torque[a]  = signed_mag[TORQUE_W-1:0];
    end
    torque_q.push_back(cmd);
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offers one sample word and predicts its command once it is taken.
  // tvalid stays high on return; the caller sends again or lowers it.
  task automatic send_sample(input sample_t smp);
    while (!no_idle && $urandom_range(99) < 27) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'(smp);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    accept_sample(smp);
  endtask

  function automatic sample_t make_sample(input int x, input int y, input int z);
    sample_t smp;
    smp[0] = FIELD_W'(x);
    smp[1] = FIELD_W'(y);
    smp[2] = FIELD_W'(z);
    return smp;
  endfunction

  // One register word; cfg_valid_i is left high for back-to-back writes.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      bdot_pkg::REG_GAIN:  gain_sh  = data[GAIN_W-1:0];
      bdot_pkg::REG_RATE:  rate_sh  = data[RATE_W-1:0];
      bdot_pkg::REG_LIMIT: limit_sh = data[LIM_W-1:0];
      default: ;   // undecoded index, no effect
    endcase
  endtask

  // Only called with the block idle. Upper garbage bits on the narrow
  // registers check that they are dropped.
  task automatic apply_config(input logic [31:0] gain, input logic [31:0] rate,
                              input logic [31:0] limit);
    write_reg(bdot_pkg::REG_GAIN, gain);
    write_reg(REG_UNUSED, $urandom);
    write_reg(bdot_pkg::REG_RATE, rate);
    write_reg(bdot_pkg::REG_LIMIT, limit);
    cfg_valid_i <= 1'b0;
  endtask

  // Sender pause: lowers tvalid and waits for every owed command.
  task automatic wait_all_torques();
    s_axis_tvalid <= 1'b0;
    while (torque_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Torque sink and checker
  // ---------------------------------------------------------------------------

  initial begin : torque_sink
    int held;
    bit hold_done;
    hold_done     = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done      = 1'b1;
        m_axis_tready <= 1'b0;
        for (held = 1; held < HOLD_CYCLES; held++) @(posedge clk_i);
      end else begin
        m_axis_tready <= no_idle || ($urandom_range(99) >= 27);
      end
    end
  end

  always @(posedge clk_i) begin : torque_check
    torque_t want;
    axes_t   got;
    int      a;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[3*TORQUE_W-1:0];
      if (torque_q.size() == 0) begin
        $display("%t unexpected torque word: x %0d y %0d z %0d limited %b", $time,
                 $signed(got[0]), $signed(got[1]), $signed(got[2]), m_axis_tuser);
        errors++;
      end else begin
        want = torque_q.pop_front();
        for (a = 0; a < 3; a++) begin
          if (got[a] !== want.torque[a]) begin
            $display("%t torque axis %0d mismatch: expected %0d, actual %0d", $time, a,
                     $signed(want.torque[a]), $signed(got[a]));
            errors++;
          end
        end
        if (m_axis_tuser !== want.limited) begin
          $display("%t limited flag mismatch: expected %b, actual %b", $time,
                   want.limited, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly a random walk with steps of random scale, so both limited and
  // unlimited commands show up; some full-range and extreme values.
  function automatic sample_t next_sample();
    sample_t smp;
    field_t  step;
    int      a;
    int      scale;
    for (a = 0; a < 3; a++) begin
      case ($urandom_range(9))
        0, 1: smp[a] = FIELD_W'($urandom);
        2: begin
          case ($urandom_range(3))
            0: smp[a] = FIELD_MAX;
            1: smp[a] = FIELD_MIN;
            2: smp[a] = '0;
            default: smp[a] = '1;
          endcase
        end
        3: smp[a] = prev_field[a];
        default: begin
          scale = $urandom_range(0, 23);
          step  = FIELD_W'($urandom_range(0, (1 << scale)));
          smp[a] = $urandom_range(1) ? prev_field[a] + step : prev_field[a] - step;
        end
      endcase
    end
    return smp;
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(4))
      0: return bdot_pkg::GAIN_RST;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      3: return $urandom_range(1, 1 << 20);
      default: return $urandom_range(1 << 16, 1 << 24);
    endcase
  endfunction

  function automatic logic [31:0] pick_rate();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(4))
      0: w[RATE_W-1:0] = 16'd1;
      1: w[RATE_W-1:0] = 16'hFFFF;
      2: w[RATE_W-1:0] = bdot_pkg::RATE_RST;
      3: w[RATE_W-1:0] = RATE_W'($urandom_range(1, 65535));
      default: w[RATE_W-1:0] = RATE_W'($urandom_range(1, 400));
    endcase
    return w;
  endfunction

  function automatic logic [31:0] pick_limit();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(4))
      0: w[LIM_W-1:0] = {LIM_W{1'b1}};
      1: w[LIM_W-1:0] = bdot_pkg::LIMIT_RST;
      2: w[LIM_W-1:0] = LIM_W'($urandom_range(1, 8388607));
      3: w[LIM_W-1:0] = LIM_W'($urandom_range(1, 1000));
      default: w[LIM_W-1:0] = LIM_W'($urandom_range(1, 1 << 16));
    endcase
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values: first sample is taken against zero, then small deltas
  // around the default limit (100000 nN*m per nT at reset settings).
  task automatic test_first_sample();
    send_sample(make_sample(1000, -2000, 3000));
    send_sample(make_sample(1000, -2000, 3000));   // no change, zero torque
    send_sample(make_sample(1001, -2000, 3000));   // one axis, under the limit
    send_sample(make_sample(1000, -1999, 3000));   // two axes, still under
    send_sample(make_sample(1002, -1997, 3002));   // just over, scaled
    wait_all_torques();
  endtask

  // Full-scale swings of the field, largest differences possible.
  task automatic test_field_extremes();
    send_sample(make_sample(FIELD_MAX, FIELD_MAX, FIELD_MAX));
    send_sample(make_sample(FIELD_MIN, FIELD_MIN, FIELD_MIN));
    send_sample(make_sample(FIELD_MAX, FIELD_MIN, 0));
    send_sample(make_sample(0, 0, 0));
    send_sample(make_sample(-1, 1, -1));
    wait_all_torques();
  endtask

  // gain 1 LSB, rate 1: torque is |d| / 65536 truncated toward zero.
  task automatic test_truncation();
    apply_config(32'd1, 32'd1, 32'h007F_FFFF);
    send_sample(make_sample(0, 0, 0));
    send_sample(make_sample(65535, -65536, 131071));
    send_sample(make_sample(0, 0, 0));
    wait_all_torques();
  endtask

  // All registers at their maxima; the magnitude needs a deep shift.
  task automatic test_register_extremes();
    apply_config(32'hFFFF_FFFF, 32'h0000_FFFF, 32'h007F_FFFF);
    send_sample(make_sample(FIELD_MAX, FIELD_MIN, FIELD_MAX));
    send_sample(make_sample(FIELD_MIN, FIELD_MAX, FIELD_MIN));
    send_sample(make_sample(FIELD_MIN + 1, FIELD_MAX, FIELD_MIN));
    wait_all_torques();
  endtask

  // Zero rate, zero gain and zero limit in turn.
  task automatic test_zero_settings();
    apply_config(bdot_pkg::GAIN_RST, 32'd0, 32'(bdot_pkg::LIMIT_RST));
    send_sample(make_sample(5000, -5000, 77));
    send_sample(make_sample(FIELD_MIN, 0, FIELD_MAX));
    wait_all_torques();
    apply_config(32'd0, 32'(bdot_pkg::RATE_RST), 32'(bdot_pkg::LIMIT_RST));
    send_sample(make_sample(FIELD_MAX, 3, -3));
    send_sample(make_sample(-4, 4, FIELD_MIN));
    wait_all_torques();
    // any nonzero torque is flagged and forced to zero
    apply_config(bdot_pkg::GAIN_RST, 32'(bdot_pkg::RATE_RST), 32'd0);
    send_sample(make_sample(-3, 4, FIELD_MIN));
    send_sample(make_sample(-3, 4, FIELD_MIN));
    wait_all_torques();
  endtask

  // Writing the undecoded index must leave the defaults in place.
  task automatic test_unknown_register();
    apply_config(bdot_pkg::GAIN_RST, 32'(bdot_pkg::RATE_RST), 32'(bdot_pkg::LIMIT_RST));
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    cfg_valid_i <= 1'b0;
    send_sample(make_sample(-2, 4, FIELD_MIN + 1));
    wait_all_torques();
  endtask

  // Sink stalls for a long stretch while samples keep coming, so the
  // output register fills and the block stops taking input.
  task automatic test_output_stall();
    int k;
    no_idle  <= 1'b1;
    hold_req <= 1'b1;
    for (k = 0; k < 10; k++) send_sample(next_sample());
    no_idle  <= 1'b0;
    hold_req <= 1'b0;
    wait_all_torques();
  endtask

  // Random settings per phase; the first phase keeps reset values, the
  // second runs without any idling on either side.
  task automatic test_random_phases();
    int phase;
    int k;
    for (phase = 0; phase < PHASES; phase++) begin
      wait_all_torques();
      no_idle <= (phase == 1);
      if (phase == 0) begin
        apply_config(bdot_pkg::GAIN_RST, 32'(bdot_pkg::RATE_RST),
                     32'(bdot_pkg::LIMIT_RST));
      end else begin
        apply_config(pick_gain(), pick_rate(), pick_limit());
      end
      for (k = 0; k < PHASE_WORDS; k++) send_sample(next_sample());
    end
    no_idle <= 1'b0;
    wait_all_torques();
  endtask

  initial begin : stimulus
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = bdot_pkg::REG_GAIN;
    cfg_data_i    = '0;
    no_idle       = 1'b0;
    hold_req      = 1'b0;
    gain_sh       = bdot_pkg::GAIN_RST;
    rate_sh       = bdot_pkg::RATE_RST;
    limit_sh      = bdot_pkg::LIMIT_RST;
    for (int a = 0; a < 3; a++) prev_field[a] = '0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_first_sample();
    test_field_extremes();
    test_truncation();
    test_register_extremes();
    test_zero_settings();
    test_unknown_register();
    test_output_stall();
    test_random_phases();

    wait_all_torques();
    // let any stray word surface before the verdict
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("[bdot_detumble_torque] OK");
    end else begin
      $display("[bdot_detumble_torque] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bdot_pkg.sv
rtl/bdot_detumble_torque.sv
tb/sv/tb_bdot_detumble_torque.sv
